[rtl/rau_pkg.sv]
// shared constants and types for the rational arithmetic unit
package rau_pkg;
	localparam int OperandWidth = 32;
	localparam int DenWidth = OperandWidth - 1;
	localparam int WideWidth = 64;

	typedef enum logic [1:0] {
		OP_SUM  = 2'd0,
		OP_DIFF = 2'd1,
		OP_PROD = 2'd2,
		OP_QUOT = 2'd3
	} op_t;

	typedef struct packed {
		logic [31:0] first_numerator;
		logic [30:0] first_denominator;
		logic [31:0] second_numerator;
		logic [30:0] second_denominator;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic        is_infinite;
		logic        is_negative;
		logic [62:0] whole_part;
		logic [61:0] fraction_numerator;
		logic [62:0] fraction_denominator;
		logic        last_result;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture operands
		logic mul_start;  // register products for op
		logic form;       // form num/den for op
		logic div_start;  // start divide of the operands selected by mode
		logic gcd_init;   // x <= den, y <= remainder
		logic fin_init;   // divide remainder by gcd
		logic fin2_init;  // divide den by gcd
		logic emit;       // build output item
		op_t  op;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_busy;
		logic den_zero;
		logic num_zero;
		logic rem_zero;
		logic y_zero;
	} stat_t;
endpackage

[rtl/rau_stream_if.sv]
// valid/ready channel carrying one payload
interface rau_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[rtl/rau_divider.sv]
// 64-bit restoring divider, one quotient bit per cycle
module rau_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        busy,
	output logic [63:0] quotient,
	output logic [63:0] remainder
);
	logic [63:0] quo_q, rem_q, dvs_q;
	logic [6:0]  cnt_q;
	logic [64:0] trial;
	logic [63:0] shifted;

	assign shifted = {rem_q[62:0], quo_q[63]};
	assign trial = {rem_q, quo_q[63]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 7'd64;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quotient = quo_q;
	assign remainder = rem_q;
endmodule

[rtl/rau_datapath.sv]
// operand registers, multiplier, shared divider and gcd registers
module rau_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  rau_pkg::in_item_t   in_item,
	input  rau_pkg::cmd_t       cmd,
	output rau_pkg::stat_t      stat,
	output rau_pkg::out_item_t  out_item
);
	import rau_pkg::*;

	logic signed [32:0] a_q, b_q, c_q, d_q;
	logic signed [32:0] mul_x, mul_y;
	logic signed [65:0] mul_p;
	logic signed [63:0] ad_q, bc_q, bd_q, ac_q;
	logic [63:0] an_q, aden_q;
	logic        neg_q, inf_q, numz_q;
	logic [63:0] whole_q, rem_q, gx_q, gy_q, g_q, fn_q;
	logic [63:0] div_a, div_b, div_quo, div_rem;
	logic        div_busy;
	logic signed [63:0] num_c, den_c;
	logic [1:0]  mode_q; // 0 whole, 1 gcd, 2 fn, 3 fd

	always_comb begin
		case (cmd.op)
			OP_SUM: begin mul_x = a_q; mul_y = d_q; end
			OP_DIFF: begin mul_x = b_q; mul_y = c_q; end
			OP_PROD: begin mul_x = b_q; mul_y = d_q; end
			default: begin mul_x = a_q; mul_y = c_q; end
		endcase
	end

	assign mul_p = mul_x * mul_y;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= 33'(signed'(in_item.first_numerator[OperandWidth-1:0]));
			b_q <= 33'(in_item.first_denominator[DenWidth-1:0]);
			c_q <= 33'(signed'(in_item.second_numerator[OperandWidth-1:0]));
			d_q <= 33'(in_item.second_denominator[DenWidth-1:0]);
		end
		// one shared multiplier, one product per cycle
		if (cmd.mul_start) begin
			case (cmd.op)
				OP_SUM: ad_q <= mul_p[63:0];
				OP_DIFF: bc_q <= mul_p[63:0];
				OP_PROD: bd_q <= mul_p[63:0];
				default: ac_q <= mul_p[63:0];
			endcase
		end
	end

	always_comb begin
		case (cmd.op)
			OP_SUM: begin num_c = ad_q + bc_q; den_c = bd_q; end
			OP_DIFF: begin num_c = ad_q - bc_q; den_c = bd_q; end
			OP_PROD: begin num_c = ac_q; den_c = bd_q; end
			default: begin num_c = ad_q; den_c = bc_q; end
		endcase
	end

	always_comb begin
		case (mode_q)
			2'd1: begin div_a = gx_q; div_b = gy_q; end
			2'd2: begin div_a = rem_q; div_b = g_q; end
			2'd3: begin div_a = aden_q; div_b = g_q; end
			default: begin div_a = an_q; div_b = aden_q; end
		endcase
	end

	rau_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(div_a), .divisor(div_b),
		.busy(div_busy), .quotient(div_quo), .remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 2'd0;
		end else if (cmd.form) begin
			mode_q <= 2'd0;
		end else if (cmd.gcd_init) begin
			mode_q <= 2'd1;
		end else if (cmd.fin_init) begin
			mode_q <= 2'd2;
		end else if (cmd.fin2_init) begin
			mode_q <= 2'd3;
		end
	end

	logic div_done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_done_q <= 1'b0;
		end else begin
			div_done_q <= div_busy;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.form) begin
			inf_q <= (den_c == 0);
			numz_q <= (num_c == 0);
			neg_q <= (num_c < 0) != (den_c < 0);
			an_q <= num_c < 0 ? 64'(-num_c) : 64'(num_c);
			aden_q <= den_c < 0 ? 64'(-den_c) : 64'(den_c);
			whole_q <= '0;
			rem_q <= '0;
			fn_q <= '0;
			g_q <= 64'd1;
		end
		// capture on the falling edge of busy
		if (div_done_q && !div_busy) begin
			case (mode_q)
				2'd0: begin whole_q <= div_quo; rem_q <= div_rem; end
				2'd1: begin gx_q <= gy_q; gy_q <= div_rem; end
				2'd2: fn_q <= div_quo;
				default: g_q <= div_quo;
			endcase
		end
		if (cmd.gcd_init) begin
			gx_q <= aden_q;
			gy_q <= rem_q;
		end
		if (cmd.fin_init) g_q <= gx_q;
	end

	assign stat.div_busy = div_busy || (!div_done_q ? 1'b0 : 1'b1);
	assign stat.den_zero = inf_q;
	assign stat.num_zero = numz_q;
	assign stat.rem_zero = (rem_q == 0);
	assign stat.y_zero = (gy_q == 0);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_item.operation <= cmd.op;
			out_item.is_infinite <= inf_q;
			out_item.is_negative <= !inf_q && !numz_q && neg_q;
			out_item.whole_part <= (inf_q || numz_q) ? '0 : whole_q[62:0];
			out_item.fraction_numerator <= (inf_q || numz_q || rem_q == 0) ?
				'0 : fn_q[61:0];
			out_item.fraction_denominator <= (inf_q || numz_q || rem_q == 0) ?
				63'd1 : g_q[62:0];
			out_item.last_result <= (cmd.op == OP_QUOT);
		end
	end
endmodule

[rtl/rau_controller.sv]
// sequencer over the four results of one transaction
module rau_controller (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  rau_pkg::stat_t stat,
	output rau_pkg::cmd_t  cmd
);
	import rau_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_FORM, S_CHECK, S_DIV,
		S_GCD, S_GCDW, S_FIN, S_FINW, S_FIN2, S_FIN2W, S_EMIT, S_OUT
	} state_t;

	state_t state_q;
	op_t    op_q;
	logic   wait_q;

	always_comb begin
		cmd = '0;
		cmd.op = op_q;
		case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_MUL0: begin cmd.mul_start = 1'b1; cmd.op = OP_SUM; end
			S_MUL1: begin cmd.mul_start = 1'b1; cmd.op = OP_DIFF; end
			S_MUL2: begin cmd.mul_start = 1'b1; cmd.op = OP_PROD; end
			S_MUL3: begin cmd.mul_start = 1'b1; cmd.op = OP_QUOT; end
			S_FORM: cmd.form = 1'b1;
			S_CHECK: cmd.div_start = !stat.den_zero && !stat.num_zero;
			S_GCD: cmd.div_start = !wait_q && !stat.y_zero;
			S_FIN: cmd.fin_init = !wait_q;
			S_FINW: cmd.div_start = !wait_q;
			S_FIN2: cmd.fin2_init = !wait_q && !stat.div_busy;
			S_FIN2W: cmd.div_start = !wait_q;
			S_EMIT: cmd.emit = 1'b1;
			default: ;
		endcase
		if (state_q == S_DIV && !stat.div_busy && !wait_q && !stat.rem_zero)
			cmd.gcd_init = 1'b1;
	end

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_SUM;
			out_valid <= 1'b0;
			wait_q <= 1'b0;
		end else begin
			wait_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_MUL0;
				S_MUL0: state_q <= S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_MUL3;
				S_MUL3: begin op_q <= OP_SUM; state_q <= S_FORM; end
				S_FORM: state_q <= S_CHECK;
				S_CHECK: begin
					if (stat.den_zero || stat.num_zero) state_q <= S_EMIT;
					else begin state_q <= S_DIV; wait_q <= 1'b1; end
				end
				S_DIV: if (!wait_q && !stat.div_busy) begin
					if (stat.rem_zero) state_q <= S_EMIT;
					else begin state_q <= S_GCD; wait_q <= 1'b1; end
				end
				S_GCD: if (!wait_q) begin
					if (stat.y_zero) begin state_q <= S_FIN; wait_q <= 1'b1; end
					else begin state_q <= S_GCDW; wait_q <= 1'b1; end
				end
				S_GCDW: if (!wait_q && !stat.div_busy) begin
					state_q <= S_GCD; wait_q <= 1'b1;
				end
				S_FIN: if (!wait_q) begin state_q <= S_FINW; wait_q <= 1'b1; end
				S_FINW: if (!wait_q) begin state_q <= S_FIN2; wait_q <= 1'b1; end
				S_FIN2: if (!wait_q && !stat.div_busy) begin
					state_q <= S_FIN2W; wait_q <= 1'b1;
				end
				S_FIN2W: if (!wait_q) begin state_q <= S_OUT; wait_q <= 1'b1; end
				S_OUT: if (!wait_q && !stat.div_busy) state_q <= S_EMIT;
				S_EMIT: begin state_q <= S_MUL0; out_valid <= 1'b1; end
				default: state_q <= S_IDLE;
			endcase
			// hold in the mul0 slot while the result waits
			if (state_q == S_MUL0 && op_q != OP_SUM) state_q <= S_MUL0;
			if (out_valid) begin
				state_q <= state_q;
				if (out_ready) begin
					out_valid <= 1'b0;
					if (op_q == OP_QUOT) begin
						state_q <= S_IDLE;
						op_q <= OP_SUM;
					end else begin
						op_q <= op_t'(op_q + 2'd1);
						state_q <= S_FORM;
					end
				end
			end
		end
	end
endmodule

[rtl/rational_arithmetic_unit.sv]
// top level: exact sum, difference, product and quotient of two fractions
//
//  channel   dir   payload                           per transaction
//  in_ch     in    two numerator/denominator pairs   one
//  out_ch    out   sign, whole part, reduced fraction four
//
// each input is loaded and its four products are registered in turn on the shared
// multiplier; each result then needs the whole-part divide, one divide per gcd
// step and the two reducing divides, all on the one shared restoring divider.
// a zero or infinite result skips the divides. arst_n clears the sequencer and
// the divider count; a stalled result holds its register and the sequencer until
// taken. a new input is taken only after the quotient.
module rational_arithmetic_unit (
	input logic clk,
	input logic arst_n,
	rau_stream_if.sink   in_ch,
	rau_stream_if.source out_ch
);
	import rau_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	out_item_t out_item;

	rau_controller u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.stat(stat), .cmd(cmd)
	);

	rau_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_ch.payload),
		.cmd(cmd), .stat(stat), .out_item(out_item)
	);

	assign out_ch.payload = out_item;
endmodule
